### sv/srpg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpg_pkg: shared types and constants of the stepper ramp pulse generator
// Request and response payloads, action codes, register indexes.
// ----------------------------------------------------------------------------
package srpg_pkg;

	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_START = 2'd2,
		ACT_STOP  = 2'd3
	} action_t;

	// configuration register indexes
	localparam logic [2:0] CFG_PLANNED_STEPS = 3'd0;
	localparam logic [2:0] CFG_RAMP_STEPS    = 3'd1;
	localparam logic [2:0] CFG_CRUISE_PERIOD = 3'd2;
	localparam logic [2:0] CFG_DIRECTION_FWD = 3'd3;
	localparam logic [2:0] CFG_CONSTANT_MODE = 3'd4;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 16;

	// first interval after a start, in ticks
	localparam logic [31:0] FIRST_INTERVAL = 32'd500;
	localparam logic [15:0] CRUISE_RESET   = 16'd1000;

	typedef struct packed {
		action_t     action;
		logic [7:0]  table_index;
		logic [15:0] table_value;
	} req_t;

	typedef struct packed {
		logic               step_level;
		logic               step_event;
		logic signed [31:0] position;
		logic [15:0]        steps_done;
		logic               running;
	} rsp_t;

endpackage

### sv/srpg_ramp_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpg_ramp_mem: ramp interval table
// One write port, one read port with registered read data; data holds
// until the next read.
// ----------------------------------------------------------------------------
module srpg_ramp_mem #(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned AW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [15:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [15:0]   rdata
);

	logic [15:0] mem [DEPTH];
	logic [15:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### sv/stepper_ramp_pulse_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_ramp_pulse_generator_unit: step pulse generator, trapezoidal ramp
// One stepper channel driven by tick, table write, start and stop requests.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall / req): one action per request.
//   A tick counts the interval down while a move runs; on expiry the step
//   pin toggles, position moves one step and the step count advances.
//   Table writes fill the ramp table (an on-chip memory). Start and stop
//   begin and end a move.
//   Response channel (rsp_valid / rsp_stall / rsp): exactly one response
//   per request, in order, carrying pin level, step event, position,
//   step count and running flag after that request.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always
//   ready; writes take effect on the next request.
//   Throughput: one request per clock while req_stall is low. Responses
//   are registered in the head entry, or the skid entry if it stalls.
//   The reloaded interval is read from the ramp memory in the cycle of the
//   step and used by the next tick, so ticks may follow every cycle.
//   Stall: a two-entry response queue lets one more request in while a
//   response waits; req_stall rises only when both entries are full.
//   Reset: counters, position, pin and move state clear; registers take
//   their reset values; the ramp table is undefined until written.
// ----------------------------------------------------------------------------
module stepper_ramp_pulse_generator_unit #(
	parameter int unsigned TABLE_DEPTH    = 256,
	parameter int unsigned INTERVAL_WIDTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  req_valid,
	output logic                                  req_stall,
	input  srpg_pkg::req_t                        req,
	output logic                                  rsp_valid,
	input  logic                                  rsp_stall,
	output srpg_pkg::rsp_t                        rsp,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [srpg_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [srpg_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int unsigned AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned IDXW    = (AW > 8) ? AW : 8;
	localparam logic [31:0] DEPTH32 = 32'(TABLE_DEPTH);
	localparam logic [31:0] IMAX    = 32'((64'd1 << INTERVAL_WIDTH) - 64'd1);

	// configuration registers
	logic [15:0] planned_q;
	logic [7:0]  ramp_q;
	logic [15:0] cruise_q;
	logic        fwd_q;
	logic        const_q;

	// move state
	logic [INTERVAL_WIDTH-1:0] cd_q;
	logic                      pend_q;   // countdown comes from ramp read data
	logic [15:0]               step_q;
	logic [31:0]               pos_q;
	logic                      level_q;
	logic                      active_q;

	// response queue
	logic           rsp_valid_q;
	srpg_pkg::rsp_t rsp_q;
	logic           skid_valid_q;
	srpg_pkg::rsp_t skid_q;

	logic                      acc;
	logic                      rsp_take;
	logic [15:0]               rd_data;
	logic                      mem_we;
	logic                      mem_re;
	logic [IDXW-1:0]           widx_ext;
	logic [INTERVAL_WIDTH-1:0] rd_clamped;
	logic [INTERVAL_WIDTH-1:0] cruise_clamped;
	logic [INTERVAL_WIDTH-1:0] first_clamped;
	logic [INTERVAL_WIDTH-1:0] eff_cd;
	logic                      expire;
	logic [15:0]               step_inc;
	logic                      finish;
	logic [15:0]               ramp16;
	logic                      near_start;
	logic                      decel;
	logic [15:0]               tbl_idx;
	logic                      use_tbl;

	logic [INTERVAL_WIDTH-1:0] cd_d;
	logic                      pend_d;
	logic [15:0]               step_d;
	logic [31:0]               pos_d;
	logic                      level_d;
	logic                      active_d;
	logic                      event_d;
	srpg_pkg::rsp_t            new_rsp;

	assign acc       = req_valid && !req_stall;
	assign rsp_take  = rsp_valid_q && !rsp_stall;
	assign req_stall = skid_valid_q;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign cfg_ready = 1'b1;

	// ---------------- ramp table ----------------
	assign widx_ext = IDXW'(req.table_index);
	assign mem_we   = acc && (req.action == srpg_pkg::ACT_WRITE)
		&& (32'(req.table_index) < DEPTH32);

	srpg_ramp_mem #(
		.DEPTH(TABLE_DEPTH),
		.AW   (AW)
	) u_ramp_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(widx_ext[AW-1:0]),
		.wdata(req.table_value),
		.re   (mem_re),
		.raddr(tbl_idx[AW-1:0]),
		.rdata(rd_data)
	);

	// ---------------- interval saturation ----------------
	always_comb begin
		rd_clamped = (32'(rd_data) > IMAX) ? IMAX[INTERVAL_WIDTH-1:0]
			: INTERVAL_WIDTH'(rd_data);
		cruise_clamped = (32'(cruise_q) > IMAX) ? IMAX[INTERVAL_WIDTH-1:0]
			: INTERVAL_WIDTH'(cruise_q);
		first_clamped = (srpg_pkg::FIRST_INTERVAL > IMAX) ? IMAX[INTERVAL_WIDTH-1:0]
			: INTERVAL_WIDTH'(srpg_pkg::FIRST_INTERVAL);
	end

	// Take the pending ramp read as the live countdown. A zero interval
	// expires on the next tick just like one.
	assign eff_cd = pend_q ? rd_clamped : cd_q;
	assign expire = eff_cd <= INTERVAL_WIDTH'(1);

	// ---------------- next interval selection ----------------
	assign step_inc   = step_q + 16'd1;
	assign finish     = step_inc == planned_q;
	assign ramp16     = {8'd0, ramp_q};
	assign near_start = step_inc <= ramp16;
	assign decel      = (planned_q < ramp16) || (step_inc >= (planned_q - ramp16));
	assign tbl_idx    = near_start ? step_inc : (planned_q - step_inc);
	// an index past the table end falls back to the cruise period
	assign use_tbl    = !const_q && (near_start || decel)
		&& (32'(tbl_idx) < DEPTH32);

	// Issue the ramp read on the step itself; the data lands for the next tick.
	assign mem_re = acc && (req.action == srpg_pkg::ACT_TICK) && active_q
		&& expire && !finish && use_tbl;

	// ---------------- request processing ----------------
	always_comb begin
		cd_d     = cd_q;
		pend_d   = pend_q;
		step_d   = step_q;
		pos_d    = pos_q;
		level_d  = level_q;
		active_d = active_q;
		event_d  = 1'b0;
		if (acc) begin
			case (req.action)
				srpg_pkg::ACT_TICK: begin
					if (active_q) begin
						if (!expire) begin
							// count down, folding in any pending read
							cd_d   = eff_cd - INTERVAL_WIDTH'(1);
							pend_d = 1'b0;
						end else begin
							event_d = 1'b1;
							level_d = !level_q;
							pos_d   = fwd_q ? (pos_q + 32'd1) : (pos_q - 32'd1);
							step_d  = step_inc;
							if (finish) begin
								active_d = 1'b0;
								cd_d     = '0;
								pend_d   = 1'b0;
							end else if (use_tbl) begin
								pend_d = 1'b1;
							end else begin
								cd_d   = cruise_clamped;
								pend_d = 1'b0;
							end
						end
					end
				end
				srpg_pkg::ACT_WRITE: begin
					// table write only; the memory takes it
				end
				srpg_pkg::ACT_START: begin
					step_d   = '0;
					cd_d     = first_clamped;
					pend_d   = 1'b0;
					active_d = 1'b1;
				end
				srpg_pkg::ACT_STOP: begin
					active_d = 1'b0;
					cd_d     = '0;
					pend_d   = 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		new_rsp.step_level = level_d;
		new_rsp.step_event = event_d;
		new_rsp.position   = signed'(pos_d);
		new_rsp.steps_done = step_d;
		new_rsp.running    = active_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cd_q     <= '0;
			pend_q   <= 1'b0;
			step_q   <= '0;
			pos_q    <= '0;
			level_q  <= 1'b0;
			active_q <= 1'b0;
		end else begin
			cd_q     <= cd_d;
			pend_q   <= pend_d;
			step_q   <= step_d;
			pos_q    <= pos_d;
			level_q  <= level_d;
			active_q <= active_d;
		end
	end

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			planned_q <= '0;
			ramp_q    <= '0;
			cruise_q  <= srpg_pkg::CRUISE_RESET;
			fwd_q     <= 1'b1;
			const_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				srpg_pkg::CFG_PLANNED_STEPS: planned_q <= cfg_data;
				srpg_pkg::CFG_RAMP_STEPS:    ramp_q    <= cfg_data[7:0];
				srpg_pkg::CFG_CRUISE_PERIOD: cruise_q  <= cfg_data;
				srpg_pkg::CFG_DIRECTION_FWD: fwd_q     <= cfg_data[0];
				srpg_pkg::CFG_CONSTANT_MODE: const_q   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// ---------------- response queue ----------------
	// Hold a second response in the skid entry while the head is stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (rsp_take) begin
					skid_valid_q <= 1'b0;
				end
			end else if (acc) begin
				if (!rsp_valid_q || rsp_take) begin
					rsp_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (rsp_take) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (rsp_take) begin
				rsp_q <= skid_q;
			end
		end else if (acc) begin
			if (!rsp_valid_q || rsp_take) begin
				rsp_q <= new_rsp;
			end else begin
				skid_q <= new_rsp;
			end
		end
	end

	// ---------------- assertions ----------------
	a_skid_behind_head: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> rsp_valid_q)
		else $error("skid entry full while head entry empty");

	a_rsp_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> rsp_valid)
		else $error("accepted request left no response");

	a_pend_in_move: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> active_q)
		else $error("ramp read pending outside a move");

	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (req.action == srpg_pkg::ACT_START)) |=> (active_q && (step_q == 16'd0)))
		else $error("start did not begin a move");

	a_read_on_step: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |=> (pend_q && (step_q == $past(step_inc))))
		else $error("ramp read without matching step");

endmodule
